>>> src/erpc_pkg.sv
// Shared types, register codes and helpers for the empty rectangle placement counter.
package erpc_pkg;

    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;
    localparam int CFG_W        = 7;
    localparam int RUN_W        = 7;
    localparam int TOTAL_W      = 14;
    localparam int APB_AW       = 4;
    localparam int APB_DW       = 32;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [RUN_W-1:0]   RUN_MAX   = 7'd127;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 14'd16383;

    typedef enum logic [1:0] {
        REG_BUILDING_HEIGHT = 2'd0,
        REG_BUILDING_WIDTH  = 2'd1,
        REG_GRID_ROWS       = 2'd2,
        REG_GRID_COLS       = 2'd3
    } t_reg_idx;

    // Classification of one cell, handed from front to back.
    typedef struct packed {
        logic occupied;
        logic known;     // column entry was written earlier in this grid
        logic row_end;
        logic grid_end;
    } t_cell_flags;

    function automatic logic [RUN_W-1:0] sat_inc_run(input logic [RUN_W-1:0] v);
        return (v >= RUN_MAX) ? RUN_MAX : v + RUN_W'(1);
    endfunction

endpackage

>>> src/erpc_front.sv
// Front end: accepts cells, tracks raster position and classifies each cell.
module erpc_front import erpc_pkg::*; #(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS,
    localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int CCW = CW + 1,
    localparam int CRW = RW + 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_occupied,
    input  logic [CFG_W-1:0]  i_grid_rows,
    input  logic [CFG_W-1:0]  i_grid_cols,
    input  logic              i_full,
    output logic              o_push,
    output t_cell_flags       o_flags,
    output logic [CW-1:0]     o_col
);

    logic [CW-1:0]  r_col, n_col;
    logic [RW-1:0]  r_row, n_row;
    logic [CCW-1:0] r_fill, n_fill;
    logic [CCW-1:0] cols, c_next;
    logic [CRW-1:0] rows, r_next;
    logic [CW-1:0]  c;
    logic           col_end, row_last;

    always_comb begin
        if (i_grid_cols == '0) begin
            cols = CCW'(1);
        end else if (int'(i_grid_cols) > MAX_COLS) begin
            cols = CCW'(MAX_COLS);
        end else begin
            cols = CCW'(i_grid_cols);
        end
        if (i_grid_rows == '0) begin
            rows = CRW'(1);
        end else if (int'(i_grid_rows) > MAX_ROWS) begin
            rows = CRW'(MAX_ROWS);
        end else begin
            rows = CRW'(i_grid_rows);
        end
    end

    always_comb begin
        if (int'(r_col) >= MAX_COLS) begin
            c = CW'(MAX_COLS - 1);
        end else begin
            c = r_col;
        end
        c_next   = {1'b0, c} + CCW'(1);
        r_next   = {1'b0, r_row} + CRW'(1);
        col_end  = (c_next >= cols);
        row_last = (r_next >= rows);

        o_stall          = i_full;
        o_push           = i_valid && !i_full;
        o_col            = c;
        o_flags.occupied = i_occupied;
        o_flags.known    = ({1'b0, c} < r_fill);
        o_flags.row_end  = col_end;
        o_flags.grid_end = col_end && row_last;

        n_col  = r_col;
        n_row  = r_row;
        n_fill = r_fill;
        if (o_push) begin
            n_fill = (c_next > r_fill) ? c_next : r_fill;
            if (col_end) begin
                n_col = '0;
                if (row_last) begin
                    n_row  = '0;
                    n_fill = '0;
                end else begin
                    n_row = r_next[RW-1:0];
                end
            end else begin
                n_col = c_next[CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_fill <= '0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_fill <= n_fill;
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_fill) <= MAX_COLS)
        else $error("fill count past column capacity");

endmodule

>>> src/erpc_queue.sv
// Two-entry queue between front and back ends.
module erpc_queue import erpc_pkg::*; #(
    parameter int MAX_COLS = DEF_MAX_COLS,
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_cell_flags   i_flags,
    input  logic [CW-1:0] i_col,
    output logic          o_full,
    output logic          o_valid,
    output t_cell_flags   o_flags,
    output logic [CW-1:0] o_col,
    input  logic          i_pop
);

    t_cell_flags   r_flags [QUEUE_DEPTH];
    logic [CW-1:0] r_cols  [QUEUE_DEPTH];
    logic          r_wr_ptr, r_rd_ptr;
    logic [1:0]    r_count;

    assign o_full  = (r_count == 2'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_flags = r_flags[r_rd_ptr];
    assign o_col   = r_cols[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_flags[r_wr_ptr] <= i_flags;
            r_cols[r_wr_ptr]  <= i_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (i_pop)  r_rd_ptr <= ~r_rd_ptr;
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full && !i_pop |=> r_count == 2'(QUEUE_DEPTH))
        else $error("queue entry lost");

endmodule

>>> src/erpc_back.sv
// Back end: column run memory, span tracking, total and result register.
module erpc_back import erpc_pkg::*; #(
    parameter int MAX_COLS = DEF_MAX_COLS,
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  t_cell_flags        i_flags,
    input  logic [CW-1:0]      i_col,
    output logic               o_pop,
    input  logic [CFG_W-1:0]   i_height,
    input  logic [CFG_W-1:0]   i_width,
    output logic               o_valid,
    output logic [TOTAL_W-1:0] o_placement_count,
    input  logic               i_stall
);

    logic [RUN_W-1:0]   mem [MAX_COLS];

    logic               r_s_valid;
    t_cell_flags        r_s_flags;
    logic [CW-1:0]      r_s_col;
    logic [RUN_W-1:0]   r_rd_data;
    logic               r_byp;
    logic [RUN_W-1:0]   r_byp_val;
    logic [RUN_W-1:0]   r_up, n_up;
    logic [RUN_W-1:0]   r_rot, n_rot;
    logic [TOTAL_W-1:0] r_total, n_total;

    logic               s_done;
    logic               both;
    logic               add_up, add_rot;
    logic [RUN_W-1:0]   old_run, run, up_next, rot_next;
    logic [TOTAL_W:0]   sum;
    logic [TOTAL_W-1:0] total_next;

    always_comb begin
        s_done = r_s_valid && !(r_s_flags.grid_end && o_valid && i_stall);
        o_pop  = i_q_valid && (!r_s_valid || s_done);

        // a column not yet written in this grid starts from zero, even when
        // the forward path carries a run left over from the previous grid
        if (!r_s_flags.known) begin
            old_run = '0;
        end else if (r_byp) begin
            old_run = r_byp_val;
        end else begin
            old_run = r_rd_data;
        end
        run = r_s_flags.occupied ? '0 : sat_inc_run(old_run);

        both     = (i_height != '0) && (i_width != '0);
        up_next  = (both && run >= i_height) ? sat_inc_run(r_up)  : '0;
        rot_next = (both && run >= i_width)  ? sat_inc_run(r_rot) : '0;
        add_up   = both && (up_next >= i_width);
        add_rot  = both && (i_height != i_width) && (rot_next >= i_height);

        sum = {1'b0, r_total} + (TOTAL_W+1)'(add_up) + (TOTAL_W+1)'(add_rot);
        total_next = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TOTAL_W-1:0];

        n_up    = r_up;
        n_rot   = r_rot;
        n_total = r_total;
        if (s_done) begin
            n_up    = r_s_flags.row_end ? '0 : up_next;
            n_rot   = r_s_flags.row_end ? '0 : rot_next;
            n_total = r_s_flags.grid_end ? '0 : total_next;
        end
    end

    // Column run memory: one read on pop, one write on completion.
    always_ff @(posedge i_clk) begin
        if (s_done) begin
            mem[r_s_col] <= run;
        end
        if (o_pop) begin
            r_rd_data <= mem[i_col];
            r_s_flags <= i_flags;
            r_s_col   <= i_col;
            r_byp     <= s_done && (r_s_col == i_col);
            r_byp_val <= run;
        end
        if (s_done && r_s_flags.grid_end) begin
            o_placement_count <= total_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
            r_up      <= '0;
            r_rot     <= '0;
            r_total   <= '0;
            o_valid   <= 1'b0;
        end else begin
            r_up    <= n_up;
            r_rot   <= n_rot;
            r_total <= n_total;
            if (o_pop) begin
                r_s_valid <= 1'b1;
            end else if (s_done) begin
                r_s_valid <= 1'b0;
            end
            if (s_done && r_s_flags.grid_end) begin
                o_valid <= 1'b1;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
        end
    end

    a_result_posted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_done && r_s_flags.grid_end |=> o_valid && o_placement_count == $past(total_next))
        else $error("grid total not posted");

    a_total_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_done && r_s_flags.grid_end |=> r_total == '0 && r_up == '0 && r_rot == '0)
        else $error("grid state not cleared at grid end");

    a_bypass_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && s_done && r_s_col == i_col |=> r_byp && r_s_valid)
        else $error("column forward missed");

endmodule

>>> src/empty_rectangle_placement_count_top.sv
// Top level: configuration registers, front end, queue and back end of the placement counter.
// Throughput: one cell per cycle unless the queue or result channel stalls; the column run
//   memory is read once and written once per cell, and a forward path covers a cell that
//   follows one in the same column. The total passes the queue, stage and result registers.
// Reset: synchronous, active low; clears positions, spans, total, queue and result valid.
// The column run memory is not swept: a fill count in the front end marks written columns,
//   so the block accepts cells as soon as reset is released.
module empty_rectangle_placement_count_top import erpc_pkg::*; #(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS,
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // cell input channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_occupied,
    // result channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic [TOTAL_W-1:0] o_placement_count,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);

    // Config registers: user writes them only with no grid transaction in flight; unenforced.
    logic [CFG_W-1:0] r_height, r_width, r_grid_rows, r_grid_cols;
    t_reg_idx         reg_idx;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign reg_idx   = t_reg_idx'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height    <= CFG_W'(1);
            r_width     <= CFG_W'(1);
            r_grid_rows <= CFG_W'(64);
            r_grid_cols <= CFG_W'(64);
        end else if (cfg_write) begin
            case (reg_idx)
                REG_BUILDING_HEIGHT: r_height    <= pwdata[CFG_W-1:0];
                REG_BUILDING_WIDTH:  r_width     <= pwdata[CFG_W-1:0];
                REG_GRID_ROWS:       r_grid_rows <= pwdata[CFG_W-1:0];
                REG_GRID_COLS:       r_grid_cols <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_BUILDING_HEIGHT: prdata = APB_DW'(r_height);
            REG_BUILDING_WIDTH:  prdata = APB_DW'(r_width);
            REG_GRID_ROWS:       prdata = APB_DW'(r_grid_rows);
            REG_GRID_COLS:       prdata = APB_DW'(r_grid_cols);
            default:             prdata = '0;
        endcase
    end

    // Front end -> queue -> back end
    logic          f_push, q_full, q_valid, q_pop;
    t_cell_flags   f_flags, q_flags;
    logic [CW-1:0] f_col, q_col;

    erpc_front #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_occupied  (i_occupied),
        .i_grid_rows (r_grid_rows),
        .i_grid_cols (r_grid_cols),
        .i_full      (q_full),
        .o_push      (f_push),
        .o_flags     (f_flags),
        .o_col       (f_col)
    );

    erpc_queue #(
        .MAX_COLS (MAX_COLS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_flags (f_flags),
        .i_col   (f_col),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_flags (q_flags),
        .o_col   (q_col),
        .i_pop   (q_pop)
    );

    erpc_back #(
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (q_valid),
        .i_flags           (q_flags),
        .i_col             (q_col),
        .o_pop             (q_pop),
        .i_height          (r_height),
        .i_width           (r_width),
        .o_valid           (o_valid),
        .o_placement_count (o_placement_count),
        .i_stall           (i_stall)
    );

endmodule

>>> bench/empty_rectangle_placement_count_top_test.sv
// Testbench for the empty rectangle placement counter: directed grids, then random grids.
`timescale 1ns / 1ps

module empty_rectangle_placement_count_top_test;
    import erpc_pkg::*;

    // Sentinels for the directed table: no mid-grid register change, and
    // "take the expected total from the predictor".
    localparam int NO_CHANGE  = -1;
    localparam int FROM_MODEL = -1;

    localparam logic [63:0] ALL_CLEAR = 64'd0;
    localparam logic [63:0] ALL_OCC   = {64{1'b1}};

    // Cell pattern bit n % 64 is the occupied flag of the n-th cell in raster order.
    typedef struct packed {
        bit               do_cfg;
        logic [CFG_W-1:0] h;
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] rows;
        logic [CFG_W-1:0] cols;
        logic [63:0]      cells;
        int               mid_at;
        t_reg_idx         mid_reg;
        logic [CFG_W-1:0] mid_val;
        int               want;
    } t_grid_case;

    localparam t_grid_case GRID_CASES [19] = '{
        // reset height, width and column count: 1x1 building on one clear row of 64
        '{1'b0, 7'd1,   7'd1,   7'd64,  7'd64, ALL_CLEAR, 0,         REG_GRID_ROWS, 7'd1, 64},
        // smallest grid, clear then occupied
        '{1'b1, 7'd1,   7'd1,   7'd1,   7'd1,  ALL_CLEAR, NO_CHANGE, REG_GRID_ROWS, 7'd0, 1},
        '{1'b1, 7'd1,   7'd1,   7'd1,   7'd1,  ALL_OCC,   NO_CHANGE, REG_GRID_ROWS, 7'd0, 0},
        // zero height, zero width
        '{1'b1, 7'd0,   7'd1,   7'd2,   7'd2,  ALL_CLEAR, NO_CHANGE, REG_GRID_ROWS, 7'd0, 0},
        '{1'b1, 7'd2,   7'd0,   7'd2,   7'd2,  ALL_CLEAR, NO_CHANGE, REG_GRID_ROWS, 7'd0, 0},
        // building larger than the grid
        '{1'b1, 7'd3,   7'd3,   7'd2,   7'd2,  ALL_CLEAR, NO_CHANGE, REG_GRID_ROWS, 7'd0, 0},
        // square building is counted once
        '{1'b1, 7'd2,   7'd2,   7'd2,   7'd2,  ALL_CLEAR, NO_CHANGE, REG_GRID_ROWS, 7'd0, 1},
        // 1x2 building: two upright plus two rotated
        '{1'b1, 7'd1,   7'd2,   7'd2,   7'd2,  ALL_CLEAR, NO_CHANGE, REG_GRID_ROWS, 7'd0, 4},
        // full-width and full-height extremes
        '{1'b1, 7'd1,   7'd64,  7'd1,   7'd64, ALL_CLEAR, NO_CHANGE, REG_GRID_ROWS, 7'd0, 1},
        '{1'b1, 7'd64,  7'd1,   7'd64,  7'd1,  ALL_CLEAR, NO_CHANGE, REG_GRID_ROWS, 7'd0, 1},
        '{1'b1, 7'd127, 7'd127, 7'd2,   7'd2,  ALL_CLEAR, NO_CHANGE, REG_GRID_ROWS, 7'd0, 0},
        // zero grid size acts as one
        '{1'b1, 7'd1,   7'd1,   7'd0,   7'd0,  ALL_CLEAR, NO_CHANGE, REG_GRID_ROWS, 7'd0, 1},
        // oversize grid clamps to the maximum
        '{1'b1, 7'd1,   7'd1,   7'd127, 7'd1,  ALL_CLEAR, NO_CHANGE, REG_GRID_ROWS, 7'd0, 64},
        '{1'b1, 7'd1,   7'd1,   7'd1,   7'd127, ALL_CLEAR, NO_CHANGE, REG_GRID_ROWS, 7'd0, 64},
        // sparse obstacles, non-square building
        '{1'b1, 7'd2,   7'd3,   7'd4,   7'd5,  64'h0000_0000_0004_0200, NO_CHANGE,
          REG_GRID_ROWS, 7'd0, FROM_MODEL},
        // column count shrinks under the current column mid-row
        '{1'b1, 7'd1,   7'd1,   7'd3,   7'd8,  64'h0000_0000_0080_0010, 5,
          REG_GRID_COLS, 7'd3, FROM_MODEL},
        // row count shrinks under the current row mid-grid
        '{1'b1, 7'd1,   7'd2,   7'd4,   7'd2,  64'h0000_0000_0000_0024, 6,
          REG_GRID_ROWS, 7'd2, FROM_MODEL},
        // diagonal occupancy: two clear cells
        '{1'b1, 7'd1,   7'd1,   7'd2,   7'd2,  64'h6, NO_CHANGE, REG_GRID_ROWS, 7'd0, 2},
        // center occupied on 3x3 with a 2x1 building: four each way
        '{1'b1, 7'd2,   7'd1,   7'd3,   7'd3,  64'h10, NO_CHANGE, REG_GRID_ROWS, 7'd0, 8}
    };

    // ---------------------------------------------------------------- DUT ports
    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               i_valid    = 1'b0;
    logic               o_stall;
    logic               i_occupied = 1'b0;
    logic               o_valid;
    logic               i_stall    = 1'b0;
    logic [TOTAL_W-1:0] o_placement_count;
    logic               psel       = 1'b0;
    logic               penable    = 1'b0;
    logic               pwrite     = 1'b0;
    logic [APB_AW-1:0]  paddr      = '0;
    logic [APB_DW-1:0]  pwdata     = '0;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    empty_rectangle_placement_count_top u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_occupied        (i_occupied),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_placement_count (o_placement_count),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------- predictor state
    // Shadow of the configuration registers, updated on every APB write.
    logic [CFG_W-1:0]   cfg_h    = 7'd1;
    logic [CFG_W-1:0]   cfg_w    = 7'd1;
    logic [CFG_W-1:0]   cfg_rows = 7'd64;
    logic [CFG_W-1:0]   cfg_cols = 7'd64;

    // Per-column clear run lengths and the row scan state of the current grid.
    logic [RUN_W-1:0]   col_run [DEF_MAX_COLS];
    int unsigned        row_at;
    int unsigned        col_at;
    logic [RUN_W-1:0]   up_span;
    logic [RUN_W-1:0]   rot_span;
    logic [TOTAL_W-1:0] grid_total;

    // Grid totals predicted but not yet seen on the result channel, oldest first.
    logic [TOTAL_W-1:0] pending_totals [$];

    int error_cnt     = 0;
    int send_idle_pct = 23;
    int stall_pct     = 57;

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_cnt++;
    endtask

    function automatic logic [RUN_W-1:0] bump_run(input logic [RUN_W-1:0] v);
        return (v == RUN_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [TOTAL_W-1:0] bump_total(input logic [TOTAL_W-1:0] v);
        return (v == TOTAL_MAX) ? v : v + 1'b1;
    endfunction

    task automatic clear_grid();
        foreach (col_run[k]) col_run[k] = '0;
        row_at     = 0;
        col_at     = 0;
        up_span    = '0;
        rot_span   = '0;
        grid_total = '0;
    endtask

    // Advance the predictor by one cell; on the last cell of the grid return its total.
    task automatic place_cell(input logic occ, output bit grid_done,
                              output logic [TOTAL_W-1:0] grid_count);
        int unsigned      rows_eff;
        int unsigned      cols_eff;
        int unsigned      c;
        logic [RUN_W-1:0] run;
        bit               both;
        rows_eff = (cfg_rows == 0) ? 1 : (cfg_rows > DEF_MAX_ROWS) ? DEF_MAX_ROWS : cfg_rows;
        cols_eff = (cfg_cols == 0) ? 1 : (cfg_cols > DEF_MAX_COLS) ? DEF_MAX_COLS : cfg_cols;
        both       = (cfg_h != 0) && (cfg_w != 0);
        grid_done  = 1'b0;
        grid_count = '0;
        c = (col_at >= DEF_MAX_COLS) ? DEF_MAX_COLS - 1 : col_at;

        run        = occ ? '0 : bump_run(col_run[c]);
        col_run[c] = run;

        // upright orientation: h rows by w columns, counted at its bottom right cell
        up_span = (both && run >= cfg_h) ? bump_run(up_span) : '0;
        if (both && up_span >= cfg_w) grid_total = bump_total(grid_total);

        // rotated orientation only when the building is not square
        rot_span = (both && run >= cfg_w) ? bump_run(rot_span) : '0;
        if (both && cfg_h != cfg_w && rot_span >= cfg_h) grid_total = bump_total(grid_total);

        // a cell at or past the last column/row closes the row/grid
        if (c + 1 >= cols_eff) begin
            col_at   = 0;
            up_span  = '0;
            rot_span = '0;
            if (row_at + 1 >= rows_eff) begin
                grid_done  = 1'b1;
                grid_count = grid_total;
                clear_grid();
            end else begin
                row_at = row_at + 1;
            end
        end else begin
            col_at = c + 1;
        end
    endtask

    // -------------------------------------------------------------- drivers
    // One APB write: setup phase, access phase, then an idle phase so that
    // back-to-back writes never assign psel twice in one time step.
    task automatic write_reg(input t_reg_idx idx, input logic [CFG_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        // upper data bits are don't-care for 7-bit registers; toggle them anyway
        pwdata  <= {(APB_DW - CFG_W)'($urandom()), val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_BUILDING_HEIGHT: cfg_h    = val;
            REG_BUILDING_WIDTH:  cfg_w    = val;
            REG_GRID_ROWS:       cfg_rows = val;
            REG_GRID_COLS:       cfg_cols = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Stop sending, let every predicted total come out, then give the pipeline
    // its latency so a cell still in flight settles before a register write.
    task automatic drain(input int settle);
        i_valid <= 1'b0;
        while (pending_totals.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [CFG_W-1:0] h, input logic [CFG_W-1:0] w,
                                input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
        write_reg(REG_BUILDING_HEIGHT, h);
        write_reg(REG_BUILDING_WIDTH,  w);
        write_reg(REG_GRID_ROWS,       rows);
        write_reg(REG_GRID_COLS,       cols);
    endtask

    // Send one cell transaction; random idle cycles go in front of it.
    // A typed total (want >= 0) replaces the predicted one for the grid it closes.
    task automatic send_cell(input logic occ, input int want, output bit grid_done);
        logic [TOTAL_W-1:0] count;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid    <= 1'b0;
            i_occupied <= 1'($urandom_range(0, 1));
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_occupied <= occ;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        place_cell(occ, grid_done, count);
        if (grid_done) pending_totals.push_back((want >= 0) ? TOTAL_W'(want) : count);
    endtask

    // ------------------------------------------------------ result checking
    // Outputs are sampled at the edge before the block's updates land; the
    // receiver's stall is redrawn at every edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_totals.size() == 0) begin
                report_mismatch($sformatf("unexpected total %0d", o_placement_count));
            end else begin
                if (o_placement_count !== pending_totals[0])
                    report_mismatch($sformatf("placement_count %0d, want %0d",
                                              o_placement_count, pending_totals[0]));
                void'(pending_totals.pop_front());
            end
        end
        i_stall <= i_rst_n && ($urandom_range(0, 99) < stall_pct);
    end

    // --------------------------------------------------------------- timeout
    initial begin
        #2_000_000;
        $display("FAIL empty_rectangle_placement_count_top");
        $finish;
    end

    // -------------------------------------------------------------- stimulus
    initial begin
        t_grid_case       tc;
        bit               done;
        int               n;
        int               kind;
        int               density;
        int               rand_items;
        int               rand_grids;
        logic [CFG_W-1:0] h;
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] rows;
        logic [CFG_W-1:0] cols;

        clear_grid();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed grids; the first runs on the reset configuration.
        for (int k = 0; k < $size(GRID_CASES); k++) begin
            tc = GRID_CASES[k];
            if (tc.do_cfg) begin
                drain(4);
                write_config(tc.h, tc.w, tc.rows, tc.cols);
            end
            n = 0;
            do begin
                if (n == tc.mid_at) begin
                    drain(4);
                    write_reg(tc.mid_reg, tc.mid_val);
                end
                send_cell(tc.cells[n % 64], tc.want, done);
                n++;
            end while (!done);
        end

        // Random grids: mostly small, now and then one dimension at full range.
        // Idling goes receiver-heavy, then sender-heavy, then none.
        rand_items = 0;
        rand_grids = 0;
        while (rand_items < 150 || rand_grids < 10) begin
            if (rand_items < 50) begin
                send_idle_pct = 23;
                stall_pct     = 57;
            end else if (rand_items < 100) begin
                send_idle_pct = 57;
                stall_pct     = 23;
            end else begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end

            if (rand_grids == 0 || $urandom_range(0, 1)) begin
                kind = $urandom_range(0, 15);
                h = ($urandom_range(0, 7) == 0) ? CFG_W'($urandom_range(0, 127))
                                                : CFG_W'($urandom_range(1, 4));
                w = ($urandom_range(0, 7) == 0) ? CFG_W'($urandom_range(0, 127))
                                                : CFG_W'($urandom_range(1, 4));
                if (kind == 0) begin
                    rows = CFG_W'($urandom_range(0, 127));
                    cols = CFG_W'($urandom_range(0, 3));
                end else if (kind == 1) begin
                    rows = CFG_W'($urandom_range(0, 3));
                    cols = CFG_W'($urandom_range(0, 127));
                end else begin
                    rows = CFG_W'($urandom_range(1, 6));
                    cols = CFG_W'($urandom_range(1, 8));
                end
                drain(4);
                write_config(h, w, rows, cols);
            end

            density = $urandom_range(0, 60);
            do begin
                // occasional register change in the middle of a grid
                if ($urandom_range(0, 79) == 0) begin
                    drain(4);
                    write_reg(t_reg_idx'($urandom_range(0, 3)), CFG_W'($urandom_range(0, 8)));
                end
                send_cell($urandom_range(0, 99) < density, FROM_MODEL, done);
                rand_items++;
            end while (!done);
            rand_grids++;
        end

        drain(8);
        if (error_cnt == 0) begin
            $display("PASS empty_rectangle_placement_count_top");
        end else begin
            $display("FAIL empty_rectangle_placement_count_top");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/erpc_pkg.sv
src/erpc_front.sv
src/erpc_queue.sv
src/erpc_back.sv
src/empty_rectangle_placement_count_top.sv
bench/empty_rectangle_placement_count_top_test.sv
